/* hw/rtl/vdu_pkg.sv */
// Package for the vector distance unit: shared constants, metric codes
// and the back-end state type. No dependencies.
package vdu_pkg;

   // Fixed result width of the distance field
   localparam int DIST_W = 48;

   // Defaults for the top-level parameters
   localparam int COORD_WIDTH_DEF = 16;
   localparam int SUM_WIDTH_DEF   = 48;

   // Entries in the queue between accumulator and root unit
   localparam int QUEUE_DEPTH = 4;

   // Metric codes as held in the select register
   localparam logic METRIC_EUCLID    = 1'b0;
   localparam logic METRIC_MANHATTAN = 1'b1;

   // Back-end sequencer states
   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_CALC,
      BACK_WRITE
   } back_state_type;

endpackage

/* hw/rtl/vdu_front.sv */
// Front end of the vector distance unit: takes coordinate pairs, forms the
// per-coordinate term and keeps the saturating running sum. Uses vdu_pkg.
module vdu_front import vdu_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int SUM_WIDTH   = SUM_WIDTH_DEF,
   parameter int REQ_W       = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
   input  logic                 clock,
   input  logic                 reset,
   // coordinate channel
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [REQ_W-1:0]     req_tdata,
   input  logic                 req_tlast,
   // metric select write
   input  logic                 csr_wr_en,
   input  logic                 csr_wr_data,
   // finished sums toward the queue
   output logic                 push_valid,
   input  logic                 push_ready,
   output logic [SUM_WIDTH-1:0] push_sum,
   output logic                 push_sat,
   output logic                 push_mode
);

   localparam int TERM_W = 2 * COORD_WIDTH;
   localparam int ACC_W  = ((SUM_WIDTH > TERM_W) ? SUM_WIDTH : TERM_W) + 1;

   logic                    metric_ff;
   logic                    v1_ff, last1_ff, mode1_ff;
   logic [COORD_WIDTH-1:0]  mag1_ff, mag1_in;
   logic                    v2_ff, last2_ff, mode2_ff;
   logic [TERM_W-1:0]       term2_ff, term2_in;
   logic [SUM_WIDTH-1:0]    sum_ff, sum_in;
   logic                    sat_ff, sat_in;
   logic                    advance;
   logic                    accept;
   logic signed [COORD_WIDTH:0] diff;
   logic [ACC_W-1:0]        total;
   logic                    over;

   // Stall the whole pipe only when a finished sum cannot enter the queue
   assign advance    = !(v2_ff && last2_ff && !push_ready);
   assign req_tready = advance;
   assign accept     = req_tvalid && advance;

   // Hold the metric select register
   always_ff @(posedge clock) begin
      if (reset) begin
         metric_ff <= METRIC_EUCLID;
      end else if (csr_wr_en) begin
         metric_ff <= csr_wr_data;
      end
   end

   // Stage 1: difference and magnitude
   always_comb begin
      diff = $signed({req_tdata[COORD_WIDTH-1], req_tdata[COORD_WIDTH-1:0]})
           - $signed({req_tdata[2*COORD_WIDTH-1], req_tdata[2*COORD_WIDTH-1:COORD_WIDTH]});
      if (diff[COORD_WIDTH]) begin
         mag1_in = COORD_WIDTH'(-diff);
      end else begin
         mag1_in = diff[COORD_WIDTH-1:0];
      end
   end

   // Stage 2: square or pass the magnitude
   always_comb begin
      if (mode1_ff == METRIC_MANHATTAN) begin
         term2_in = TERM_W'(mag1_ff);
      end else begin
         term2_in = TERM_W'(mag1_ff) * TERM_W'(mag1_ff);
      end
   end

   // Advance the pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mag1_ff  <= mag1_in;
         last1_ff <= req_tlast;
         mode1_ff <= metric_ff;
         term2_ff <= term2_in;
         last2_ff <= last1_ff;
         mode2_ff <= mode1_ff;
      end
   end

   // Saturating add of the term into the running sum
   always_comb begin
      total = ACC_W'(sum_ff) + ACC_W'(term2_ff);
      over  = total > ACC_W'({SUM_WIDTH{1'b1}});
      if (over) begin
         push_sum = {SUM_WIDTH{1'b1}};
      end else begin
         push_sum = total[SUM_WIDTH-1:0];
      end
      push_sat   = sat_ff || over;
      push_mode  = mode2_ff;
      push_valid = v2_ff && last2_ff;
      sum_in     = sum_ff;
      sat_in     = sat_ff;
      if (v2_ff && advance) begin
         if (last2_ff) begin
            sum_in = '0;
            sat_in = 1'b0;
         end else begin
            sum_in = push_sum;
            sat_in = push_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         sat_ff <= 1'b0;
      end else begin
         sum_ff <= sum_in;
         sat_ff <= sat_in;
      end
   end

endmodule

/* hw/rtl/vdu_queue.sv */
// Short queue of finished sums between the accumulator and the root unit.
// Uses vdu_pkg for its depth.
module vdu_queue import vdu_pkg::*; #(
   parameter int SUM_WIDTH = SUM_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  logic [SUM_WIDTH-1:0] push_sum,
   input  logic                 push_sat,
   input  logic                 push_mode,
   output logic                 pop_valid,
   input  logic                 pop_en,
   output logic [SUM_WIDTH-1:0] pop_sum,
   output logic                 pop_sat,
   output logic                 pop_mode
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = PTR_W + 1;

   logic [SUM_WIDTH-1:0] sum_mem [QUEUE_DEPTH];
   logic                 sat_mem [QUEUE_DEPTH];
   logic                 mode_mem [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_push, do_pop;

   assign push_ready = count_ff != CNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_en && pop_valid;
   assign pop_sum    = sum_mem[rd_ptr_ff];
   assign pop_sat    = sat_mem[rd_ptr_ff];
   assign pop_mode   = mode_mem[rd_ptr_ff];

   // Track the fill level
   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   // Write the entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         sum_mem[wr_ptr_ff]  <= push_sum;
         sat_mem[wr_ptr_ff]  <= push_sat;
         mode_mem[wr_ptr_ff] <= push_mode;
      end
   end

endmodule

/* hw/rtl/vdu_back.sv */
// Back end of the vector distance unit: iterative integer square root, one
// root bit per cycle, and the result register. Uses vdu_pkg.
module vdu_back import vdu_pkg::*; #(
   parameter int SUM_WIDTH = SUM_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   output logic                 pop_en,
   input  logic [SUM_WIDTH-1:0] pop_sum,
   input  logic                 pop_sat,
   input  logic                 pop_mode,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [DIST_W-1:0]    rsp_tdata,
   output logic                 rsp_tuser
);

   localparam int STEPS = (SUM_WIDTH + 1) / 2;
   localparam int RAD_W = 2 * STEPS;
   localparam int REM_W = STEPS + 2;
   localparam int CNT_W = $clog2(STEPS);

   back_state_type       state_ff, state_in;
   logic [RAD_W-1:0]     rad_ff, rad_in;
   logic [STEPS-1:0]     root_ff, root_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 sat_ff, sat_in;
   logic                 mode_ff, mode_in;
   logic                 out_valid_ff, out_valid_in;
   logic [DIST_W-1:0]    dist_ff, dist_in;
   logic                 ovf_ff, ovf_in;
   logic [REM_W-1:0]     rem_shift, trial;
   logic                 out_free;
   logic [DIST_W+RAD_W-1:0] sum_wide;
   logic [DIST_W+STEPS-1:0] root_wide;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = dist_ff;
   assign rsp_tuser  = ovf_ff;

   // One restoring root step: bring down two radicand bits, try 4r+1
   assign rem_shift = {rem_ff[STEPS-1:0], rad_ff[RAD_W-1:RAD_W-2]};
   assign trial     = {root_ff, 2'b01};

   // Fit the sum or the root into the distance field
   assign sum_wide  = {{DIST_W{1'b0}}, rad_ff};
   assign root_wide = {{DIST_W{1'b0}}, root_ff};

   // Sequence pop, root iterations and result load
   always_comb begin
      state_in     = state_ff;
      rad_in       = rad_ff;
      root_in      = root_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      sat_in       = sat_ff;
      mode_in      = mode_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      dist_in      = dist_ff;
      ovf_in       = ovf_ff;
      pop_en       = 1'b0;
      unique case (state_ff)
         BACK_IDLE: begin
            if (pop_valid) begin
               pop_en  = 1'b1;
               rad_in  = RAD_W'(pop_sum);
               root_in = '0;
               rem_in  = '0;
               cnt_in  = '0;
               sat_in  = pop_sat;
               mode_in = pop_mode;
               if (pop_mode == METRIC_MANHATTAN) begin
                  state_in = BACK_WRITE;
               end else begin
                  state_in = BACK_CALC;
               end
            end
         end
         BACK_CALC: begin
            rad_in = {rad_ff[RAD_W-3:0], 2'b00};
            if (rem_shift >= trial) begin
               rem_in  = rem_shift - trial;
               root_in = {root_ff[STEPS-2:0], 1'b1};
            end else begin
               rem_in  = rem_shift;
               root_in = {root_ff[STEPS-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(STEPS - 1)) begin
               state_in = BACK_WRITE;
            end
         end
         BACK_WRITE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               ovf_in       = sat_ff;
               if (mode_ff == METRIC_MANHATTAN) begin
                  dist_in = sum_wide[DIST_W-1:0];
               end else begin
                  dist_in = root_wide[DIST_W-1:0];
               end
               state_in = BACK_IDLE;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      sat_ff  <= sat_in;
      mode_ff <= mode_in;
      dist_ff <= dist_in;
      ovf_ff  <= ovf_in;
   end

endmodule

/* hw/rtl/vector_distance_unit_top.sv */
// Top level of the vector distance unit: front accumulator, sum queue and
// square-root back end. Depends on vdu_pkg, vdu_front, vdu_queue, vdu_back.
//
// Usage: stream the coordinate pairs of two vectors on the req_ channel, one
// transaction per coordinate, req_tlast on the final one. Each pair of vectors
// gives one transaction on rsp_: the distance in rsp_tdata and the saturation
// flag in rsp_tuser. csr_wr_en/csr_wr_data set the metric (0 Euclidean,
// 1 Manhattan); write it only while the block is idle.
// Throughput: one coordinate per cycle on the input while req_tready is
// high. The accumulator is a three-stage pipe (magnitude, square, add). The
// root unit after the queue produces one root bit per cycle for a Euclidean
// result and passes a Manhattan sum straight to the result register.
// A four-entry queue holds finished sums, so vectors of several coordinates
// keep the input at full rate while roots are taken.
// Reset clears the sum, the flag, the queue, the output and the metric.
// When the receiver stalls the result holds in its register; once the queue
// fills too, req_tready drops until room opens.
module vector_distance_unit_top import vdu_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int SUM_WIDTH   = SUM_WIDTH_DEF,
   parameter int REQ_W       = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [REQ_W-1:0]  req_tdata,   // coord_a, coord_b, zero fill
   input  logic              req_tlast,   // last_element
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DIST_W-1:0] rsp_tdata,   // distance
   output logic              rsp_tuser,   // overflow
   input  logic              csr_wr_en,
   input  logic              csr_wr_data  // metric_select
);

   logic                 push_valid, push_ready, push_sat, push_mode;
   logic [SUM_WIDTH-1:0] push_sum;
   logic                 pop_valid, pop_en, pop_sat, pop_mode;
   logic [SUM_WIDTH-1:0] pop_sum;

   // Accumulate terms
   vdu_front #(
      .COORD_WIDTH (COORD_WIDTH),
      .SUM_WIDTH   (SUM_WIDTH),
      .REQ_W       (REQ_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_sum    (push_sum),
      .push_sat    (push_sat),
      .push_mode   (push_mode)
   );

   // Buffer finished sums
   vdu_queue #(
      .SUM_WIDTH (SUM_WIDTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_sum   (push_sum),
      .push_sat   (push_sat),
      .push_mode  (push_mode),
      .pop_valid  (pop_valid),
      .pop_en     (pop_en),
      .pop_sum    (pop_sum),
      .pop_sat    (pop_sat),
      .pop_mode   (pop_mode)
   );

   // Take roots and drive the result
   vdu_back #(
      .SUM_WIDTH (SUM_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_en     (pop_en),
      .pop_sum    (pop_sum),
      .pop_sat    (pop_sat),
      .pop_mode   (pop_mode),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
